[hdl/keyboard_modifier_encoder_top_assert.svh]
// Assertion macros used by the keyboard modifier encoder back end.
`ifndef KEYBOARD_MODIFIER_ENCODER_TOP_ASSERT_SVH
`define KEYBOARD_MODIFIER_ENCODER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define KME_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keyboard modifier encoder: implication check failed");

// Next-cycle implication, checked outside reset.
`define KME_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keyboard modifier encoder: next-cycle check failed");

`endif

[hdl/kme_pkg.sv]
// Types and constants shared by the keyboard modifier encoder modules.
`timescale 1ns / 1ps

package kme_pkg;

    localparam int MAX_BYTES = 5;
    localparam int COUNT_W   = 3;

    localparam logic [7:0]  ESC_BYTE         = 8'h1B;
    localparam logic [15:0] TAP_WINDOW_RESET = 16'd600;
    localparam logic [20:0] CTRL_LOW_MASK    = 21'd31;
    localparam logic [20:0] CTRL_DEL_CODE    = 21'd127;
    localparam logic [20:0] CHAR_QUESTION    = 21'h3F;
    localparam logic [20:0] CHAR_AT          = 21'h40;
    localparam logic [20:0] CHAR_UNDERSCORE  = 21'h5F;
    localparam logic [20:0] CHAR_SPACE       = 21'h20;
    localparam logic [20:0] CHAR_UPPER_A     = 21'h41;
    localparam logic [20:0] CHAR_LOWER_A     = 21'h61;
    localparam logic [20:0] CHAR_LOWER_Z     = 21'h7A;
    localparam logic [20:0] CASE_OFFSET      = 21'h20;

    typedef enum logic [1:0] {
        MODE_KEY   = 2'd0,
        MODE_SHIFT = 2'd1,
        MODE_CTRL  = 2'd2,
        MODE_ALT   = 2'd3
    } t_mode;

    // One key's byte sequence as it travels from the front to the back.
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [COUNT_W-1:0]        count;
    } t_job;

endpackage

[hdl/kme_if.sv]
// Handshake interfaces for key event requests and output byte requests.
`timescale 1ns / 1ps

interface kme_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [20:0] lower_code;
    logic [20:0] upper_code;
    logic        lower_is_letter;
    logic [47:0] timestamp_ms;

    modport source (output valid, mode, lower_code, upper_code, lower_is_letter,
                    timestamp_ms, input ready);
    modport sink (input valid, mode, lower_code, upper_code, lower_is_letter,
                  timestamp_ms, output ready);
endinterface

interface kme_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       last_byte;

    modport source (output valid, byte_value, last_byte, input ready);
    modport sink (input valid, byte_value, last_byte, output ready);
endinterface

[hdl/keyboard_modifier_encoder_top.sv]
// Top level of the keyboard modifier encoder.
`timescale 1ns / 1ps

// Keyboard modifier encoder: turns key event requests into terminal bytes.
// The i_key channel carries one event request: a key press, a shift tap, or
// an arm of ctrl or alt. Shift taps and arms update the modifier state and
// give no output. A key press gives one to five byte requests on o_byte: an
// optional ESC for alt, then the UTF-8 bytes, with last_byte set on the final
// one. A ctrl key that has no control mapping gives no bytes at all.
// The tap window register is written through i_cfg_valid / o_cfg_ready and
// must only change while the block is idle; o_cfg_ready is always high.
// An accepted event goes into the job queue; the back end then loads the job
// and then the byte register. While the receiver is ready the output runs one
// byte per cycle, also across key boundaries; the front accepts one event per
// cycle while the job queue has room. When the receiver stalls, the byte
// register holds, the queue fills, and only then does i_key.ready drop. Reset
// (synchronous, active low) clears all modifiers, the tap time and the queue,
// and sets the window to 600 ms.

module keyboard_modifier_encoder_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    kme_in_if.sink      i_key,
    kme_out_if.source   o_byte,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_tap_window_ms
);
    import kme_pkg::*;

    t_job push_job;
    t_job head_job;
    logic push;
    logic pop;
    logic full;
    logic empty;

    assign o_cfg_ready = 1'b1;

    kme_front u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_key               (i_key),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_tap_window_ms (i_cfg_tap_window_ms),
        .i_full              (full),
        .o_push              (push),
        .o_job               (push_job)
    );

    kme_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_job   (head_job)
    );

    kme_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_job   (head_job),
        .o_pop   (pop),
        .o_byte  (o_byte)
    );

endmodule

[hdl/kme_fifo.sv]
// Short job queue between the front and back of the encoder.
`timescale 1ns / 1ps

module kme_fifo #(
    parameter int DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  kme_pkg::t_job i_job,
    output logic        o_full,
    input  logic        i_pop,
    output logic        o_empty,
    output kme_pkg::t_job o_job
);
    import kme_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_job             r_store [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_job   = r_store[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_store[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[hdl/kme_front.sv]
// Front end: accepts key events, keeps the modifier state and builds byte jobs.
`timescale 1ns / 1ps

module kme_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    kme_in_if.sink        i_key,
    input  logic          i_cfg_valid,
    input  logic [15:0]   i_cfg_tap_window_ms,
    input  logic          i_full,
    output logic          o_push,
    output kme_pkg::t_job o_job
);
    import kme_pkg::*;

    logic [15:0] r_tap_window;
    logic        r_shift_on;
    logic        r_caps_on;
    logic        r_ctrl_on;
    logic        r_alt_on;
    logic [47:0] r_last_tap;

    logic        accept;
    t_mode       mode;
    logic        pick_upper;
    logic [20:0] code;
    logic [20:0] folded;
    logic [20:0] mapped;
    logic        ctrl_ok;
    logic        emit;
    logic [3:0][7:0] utf;
    logic [2:0]  utf_len;
    logic [48:0] gap;
    logic        in_window;

    logic        n_shift_on;
    logic        n_caps_on;
    logic        n_ctrl_on;
    logic        n_alt_on;
    logic [47:0] n_last_tap;

    assign accept       = i_key.valid && i_key.ready;
    assign i_key.ready  = !i_full;
    assign mode         = t_mode'(i_key.mode);

    // Character selection and the ctrl mapping.
    always_comb begin
        pick_upper = r_shift_on ^ (i_key.lower_is_letter & r_caps_on);
        code       = pick_upper ? i_key.upper_code : i_key.lower_code;
        folded     = code;
        if (code >= CHAR_LOWER_A && code <= CHAR_LOWER_Z) begin
            folded = code - CASE_OFFSET;
        end
        ctrl_ok = 1'b1;
        if (folded == CHAR_SPACE || folded == CHAR_AT) begin
            mapped = '0;
        end else if (folded >= CHAR_UPPER_A && folded <= CHAR_UNDERSCORE) begin
            mapped = folded & CTRL_LOW_MASK;
        end else if (folded == CHAR_QUESTION) begin
            mapped = CTRL_DEL_CODE;
        end else begin
            mapped  = folded;
            ctrl_ok = 1'b0;
        end
        if (!r_ctrl_on) begin
            mapped  = code;
            ctrl_ok = 1'b1;
        end
        emit = ctrl_ok;
    end

    // UTF-8 encoding of the chosen code point.
    always_comb begin
        utf = '0;
        if (mapped < 21'h80) begin
            utf[0]  = mapped[7:0];
            utf_len = 3'd1;
        end else if (mapped < 21'h800) begin
            utf[0]  = {3'b110, mapped[10:6]};
            utf[1]  = {2'b10, mapped[5:0]};
            utf_len = 3'd2;
        end else if (mapped < 21'h10000) begin
            utf[0]  = {4'b1110, mapped[15:12]};
            utf[1]  = {2'b10, mapped[11:6]};
            utf[2]  = {2'b10, mapped[5:0]};
            utf_len = 3'd3;
        end else begin
            utf[0]  = {5'b11110, mapped[20:18]};
            utf[1]  = {2'b10, mapped[17:12]};
            utf[2]  = {2'b10, mapped[11:6]};
            utf[3]  = {2'b10, mapped[5:0]};
            utf_len = 3'd4;
        end
    end

    always_comb begin
        o_job = '0;
        if (r_alt_on) begin
            o_job.bytes[0]   = ESC_BYTE;
            o_job.bytes[4:1] = utf;
            o_job.count      = utf_len + 3'd1;
        end else begin
            o_job.bytes[3:0] = utf;
            o_job.count      = utf_len;
        end
    end

    // A timestamp before the last tap leaves a borrow and counts as within.
    assign gap       = {1'b0, i_key.timestamp_ms} - {1'b0, r_last_tap};
    assign in_window = gap[48] || (gap[47:0] <= {32'd0, r_tap_window});

    assign o_push = accept && (mode == MODE_KEY) && emit;

    always_comb begin
        n_shift_on = r_shift_on;
        n_caps_on  = r_caps_on;
        n_ctrl_on  = r_ctrl_on;
        n_alt_on   = r_alt_on;
        n_last_tap = r_last_tap;
        if (accept) begin
            unique case (mode)
                MODE_KEY: begin
                    if (emit) begin
                        n_shift_on = 1'b0;
                        n_ctrl_on  = 1'b0;
                        n_alt_on   = 1'b0;
                        n_last_tap = '0;
                    end
                end
                MODE_SHIFT: begin
                    if (r_caps_on) begin
                        n_caps_on  = 1'b0;
                        n_shift_on = 1'b0;
                    end else if (r_shift_on && r_last_tap != '0 && in_window) begin
                        n_caps_on  = 1'b1;
                        n_shift_on = 1'b0;
                    end else begin
                        n_shift_on = !r_shift_on;
                    end
                    n_last_tap = i_key.timestamp_ms;
                end
                MODE_CTRL: n_ctrl_on = 1'b1;
                MODE_ALT:  n_alt_on  = 1'b1;
                default:   n_alt_on  = r_alt_on;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_window <= TAP_WINDOW_RESET;
            r_shift_on   <= 1'b0;
            r_caps_on    <= 1'b0;
            r_ctrl_on    <= 1'b0;
            r_alt_on     <= 1'b0;
            r_last_tap   <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_tap_window <= i_cfg_tap_window_ms;
            end
            r_shift_on <= n_shift_on;
            r_caps_on  <= n_caps_on;
            r_ctrl_on  <= n_ctrl_on;
            r_alt_on   <= n_alt_on;
            r_last_tap <= n_last_tap;
        end
    end

endmodule

[hdl/kme_back.sv]
// Back end: takes byte jobs from the queue and sends them one byte per request.
`timescale 1ns / 1ps

module kme_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  kme_pkg::t_job i_job,
    output logic          o_pop,
    kme_out_if.source     o_byte
);
    import kme_pkg::*;

    `include "keyboard_modifier_encoder_top_assert.svh"

    t_job               r_job;
    logic               r_busy;
    logic [COUNT_W-1:0] r_idx;
    logic               r_ovalid;
    logic [7:0]         r_byte;
    logic               r_last;

    logic load;
    logic is_last;
    logic job_len_ok;

    assign load    = r_busy && (!r_ovalid || o_byte.ready);
    assign is_last = (r_idx == r_job.count - 1'b1);
    assign o_pop   = !i_empty && (!r_busy || (load && is_last));

    assign o_byte.valid      = r_ovalid;
    assign o_byte.byte_value = r_byte;
    assign o_byte.last_byte  = r_last;

    assign job_len_ok = (r_job.count != '0) && (r_job.count <= COUNT_W'(MAX_BYTES));

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= r_job.bytes[r_idx];
            r_last <= is_last;
        end
        if (o_pop) begin
            r_job <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (load) begin
                r_ovalid <= 1'b1;
            end else if (o_byte.ready) begin
                r_ovalid <= 1'b0;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (load) begin
                r_idx <= r_idx + 1'b1;
                if (is_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    `KME_ASSERT_IMPLY(a_idx_in_job, i_clk, i_rst_n, r_busy, r_idx < r_job.count)
    `KME_ASSERT_IMPLY(a_job_len, i_clk, i_rst_n, r_busy, job_len_ok)
    `KME_ASSERT_NEXT(a_pop_starts, i_clk, i_rst_n, o_pop, r_busy && (r_idx == '0))

endmodule

[sim/keyboard_modifier_encoder_top_tb.sv]
// Self-checking testbench for the keyboard modifier encoder: directed and random key events.
`timescale 1ns / 1ps

module keyboard_modifier_encoder_top_tb;
    import kme_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 1000000;
    localparam int unsigned DRAIN_CYCLES  = 8;
    localparam int unsigned PHASE_ITEMS   = 60;
    localparam int unsigned REPORT_LIMIT  = 10;

    localparam logic [20:0] UTF8_ONE_LIMIT   = 21'h80;
    localparam logic [20:0] UTF8_TWO_LIMIT   = 21'h800;
    localparam logic [20:0] UTF8_THREE_LIMIT = 21'h10000;
    localparam logic [20:0] CODE_MAX         = 21'h1FFFFF;

    typedef struct packed {
        t_mode       mode;
        logic [20:0] lower;
        logic [20:0] upper;
        logic        letter;
        logic [47:0] stamp;
    } t_key_req;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } t_out_byte;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    kme_in_if  key_if ();
    kme_out_if byte_if ();

    // Values the driver holds on the key channel.
    t_key_req    key_req    = '0;
    logic        key_valid  = 1'b0;
    logic        byte_ready = 1'b0;
    logic        cfg_valid  = 1'b0;
    logic [15:0] cfg_window = '0;
    logic        cfg_ready;

    assign key_if.valid           = key_valid;
    assign key_if.mode            = key_req.mode;
    assign key_if.lower_code      = key_req.lower;
    assign key_if.upper_code      = key_req.upper;
    assign key_if.lower_is_letter = key_req.letter;
    assign key_if.timestamp_ms    = key_req.stamp;
    assign byte_if.ready          = byte_ready;

    keyboard_modifier_encoder_top dut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_key               (key_if),
        .o_byte              (byte_if),
        .i_cfg_valid         (cfg_valid),
        .o_cfg_ready         (cfg_ready),
        .i_cfg_tap_window_ms (cfg_window)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Modifier state as the block should hold it.
    logic [15:0] window_ms  = TAP_WINDOW_RESET;
    logic        shift_held = 1'b0;
    logic        caps_lock  = 1'b0;
    logic        ctrl_armed = 1'b0;
    logic        alt_armed  = 1'b0;
    logic [47:0] prev_tap_ms = '0;

    t_out_byte   expected_bytes [$];
    t_key_req    pending_reqs [$];
    int unsigned queued_total   = 0;
    int unsigned accepted_total = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    logic        key_taken      = 1'b0;
    int unsigned key_gap        = 0;
    int unsigned key_calm       = 0;
    int unsigned stall_left     = 0;
    int unsigned byte_calm      = 0;
    logic [47:0] tap_clock      = 48'd1000;

    function automatic void note_mismatch(string what, int unsigned want, int unsigned got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("Mismatch on %s: expected 0x%0h, got 0x%0h", what, want, got);
        end
    endfunction

    // Works out the bytes that one accepted request causes and updates the modifiers.
    task automatic encode_key_request(input t_key_req req);
        logic [20:0] code;
        logic        take_upper;
        logic [7:0]  bytes_out [$];
        t_out_byte   entry;
        case (req.mode)
            MODE_KEY: begin
                take_upper = shift_held ^ (req.letter & caps_lock);
                code = take_upper ? req.upper : req.lower;
                if (ctrl_armed) begin
                    if (code >= CHAR_LOWER_A && code <= CHAR_LOWER_Z) begin
                        code = code - CASE_OFFSET;
                    end
                    if (code == CHAR_SPACE || code == CHAR_AT) begin
                        code = '0;
                    end else if (code >= CHAR_UPPER_A && code <= CHAR_UNDERSCORE) begin
                        code = code & CTRL_LOW_MASK;
                    end else if (code == CHAR_QUESTION) begin
                        code = CTRL_DEL_CODE;
                    end else begin
                        // No control mapping: nothing is sent and the modifiers stay armed.
                        return;
                    end
                end
                if (alt_armed) begin
                    bytes_out.push_back(ESC_BYTE);
                end
                if (code < UTF8_ONE_LIMIT) begin
                    bytes_out.push_back(code[7:0]);
                end else if (code < UTF8_TWO_LIMIT) begin
                    bytes_out.push_back({3'b110, code[10:6]});
                    bytes_out.push_back({2'b10, code[5:0]});
                end else if (code < UTF8_THREE_LIMIT) begin
                    bytes_out.push_back({4'b1110, code[15:12]});
                    bytes_out.push_back({2'b10, code[11:6]});
                    bytes_out.push_back({2'b10, code[5:0]});
                end else begin
                    bytes_out.push_back({5'b11110, code[20:18]});
                    bytes_out.push_back({2'b10, code[17:12]});
                    bytes_out.push_back({2'b10, code[11:6]});
                    bytes_out.push_back({2'b10, code[5:0]});
                end
                foreach (bytes_out[i]) begin
                    entry.value = bytes_out[i];
                    entry.last  = (i == bytes_out.size() - 1);
                    expected_bytes.push_back(entry);
                end
                shift_held  = 1'b0;
                ctrl_armed  = 1'b0;
                alt_armed   = 1'b0;
                prev_tap_ms = '0;
            end
            MODE_SHIFT: begin
                if (caps_lock) begin
                    caps_lock  = 1'b0;
                    shift_held = 1'b0;
                end else if (shift_held && prev_tap_ms != '0 &&
                             (req.stamp < prev_tap_ms ||
                              req.stamp - prev_tap_ms <= {32'd0, window_ms})) begin
                    // Double tap within the window locks caps.
                    caps_lock  = 1'b1;
                    shift_held = 1'b0;
                end else begin
                    shift_held = !shift_held;
                end
                prev_tap_ms = req.stamp;
            end
            MODE_CTRL: ctrl_armed = 1'b1;
            MODE_ALT:  alt_armed  = 1'b1;
        endcase
    endtask

    // Idle lengths: mostly none, some short, a few long, and calm stretches with none.
    function automatic int unsigned pick_idle(inout int unsigned calm);
        int unsigned roll;
        if (calm != 0) begin
            calm--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        if (roll < 60) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [47:0] random_stamp();
        return {16'($urandom_range(0, 65535)), $urandom()};
    endfunction

    // Code points weighted toward ASCII and the characters that ctrl maps.
    function automatic logic [20:0] random_code();
        case ($urandom_range(0, 9))
            0, 1, 2: return 21'($urandom_range(0, 127));
            3: return 21'($urandom_range(128, 2047));
            4: return 21'($urandom_range(2048, 65535));
            5: return 21'($urandom_range(65536, 1114111));
            6: return 21'($urandom());
            default: begin
                case ($urandom_range(0, 10))
                    0: return CHAR_SPACE;
                    1: return CHAR_AT;
                    2: return CHAR_QUESTION;
                    3: return CHAR_UNDERSCORE;
                    4: return CHAR_UPPER_A;
                    5: return CHAR_LOWER_A;
                    6: return CHAR_LOWER_Z;
                    7: return 21'h60;   // backtick, just above the ctrl range
                    8: return 21'h7B;   // brace, just above z
                    9: return 21'h3E;   // just below the question mark
                    default: return 21'h1F;
                endcase
            end
        endcase
    endfunction

    task automatic queue_request(input t_key_req req);
        pending_reqs.push_back(req);
        queued_total++;
    endtask

    task automatic queue_key(input logic [20:0] lower, input logic [20:0] upper,
                             input logic letter);
        t_key_req req;
        req.mode   = MODE_KEY;
        req.lower  = lower;
        req.upper  = upper;
        req.letter = letter;
        req.stamp  = random_stamp();
        queue_request(req);
    endtask

    task automatic queue_tap(input logic [47:0] stamp);
        t_key_req req;
        req.mode   = MODE_SHIFT;
        req.lower  = 21'($urandom());
        req.upper  = 21'($urandom());
        req.letter = 1'($urandom_range(0, 1));
        req.stamp  = stamp;
        queue_request(req);
    endtask

    task automatic queue_arm(input t_mode mode);
        t_key_req req;
        req.mode   = mode;
        req.lower  = 21'($urandom());
        req.upper  = 21'($urandom());
        req.letter = 1'($urandom_range(0, 1));
        req.stamp  = random_stamp();
        queue_request(req);
    endtask

    task automatic queue_random_key();
        logic [20:0] idx;
        idx = 21'($urandom_range(0, 25));
        if ($urandom_range(0, 1)) begin
            queue_key(CHAR_LOWER_A + idx, CHAR_UPPER_A + idx, 1'b1);
        end else begin
            queue_key(random_code(), random_code(), 1'($urandom_range(0, 1)));
        end
    endtask

    // Advances the tap clock; a zero stamp would read as no tap, so it is skipped.
    function automatic logic [47:0] next_tap(input logic [47:0] gap);
        tap_clock = tap_clock + gap;
        if (tap_clock == '0) tap_clock = 48'd1;
        return tap_clock;
    endfunction

    function automatic logic [47:0] pick_tap_gap();
        logic [47:0] wide;
        wide = {32'd0, window_ms};
        case ($urandom_range(0, 6))
            0: return wide;
            1: return wide + 48'd1;
            2: return '0;
            3: return wide - 48'd1;      // wraps to an earlier stamp when the window is 0
            4: return 48'($urandom_range(0, 2 * window_ms + 2));
            5: return -48'($urandom_range(1, 500));    // earlier than the last tap
            default: return random_stamp();
        endcase
    endfunction

    // Key, three taps and two more keys: walks shift, caps lock and back.
    task automatic queue_caps_cycle(input logic [47:0] gap1, input logic [47:0] gap2);
        if ($urandom_range(0, 9) == 0) begin
            tap_clock = 48'hFFFF_FFFF_0000 | 48'($urandom_range(0, 65535));
        end
        queue_random_key();
        queue_tap(next_tap(48'd70000 + 48'($urandom_range(0, 1000))));
        queue_tap(next_tap(gap1));
        queue_tap(next_tap(gap2));
        queue_random_key();
        queue_random_key();
    endtask

    task automatic queue_scenario();
        case ($urandom_range(0, 9))
            0, 1: queue_random_key();
            2: begin
                queue_tap(next_tap(pick_tap_gap()));
                queue_random_key();
            end
            3, 4: queue_caps_cycle(pick_tap_gap(), pick_tap_gap());
            5: begin
                queue_arm(MODE_CTRL);
                if ($urandom_range(0, 3) == 0) queue_arm(MODE_CTRL);
                queue_key(random_code(), random_code(), 1'($urandom_range(0, 1)));
            end
            6: begin
                queue_arm(MODE_ALT);
                queue_random_key();
            end
            7: begin
                if ($urandom_range(0, 1)) begin
                    queue_arm(MODE_CTRL);
                    queue_arm(MODE_ALT);
                end else begin
                    queue_arm(MODE_ALT);
                    queue_arm(MODE_CTRL);
                end
                queue_key(random_code(), random_code(), 1'($urandom_range(0, 1)));
            end
            default: begin
                // Noise: fully random requests of any kind.
                repeat ($urandom_range(1, 3)) begin
                    t_key_req req;
                    req.mode   = t_mode'($urandom_range(0, 3));
                    req.lower  = 21'($urandom());
                    req.upper  = 21'($urandom());
                    req.letter = 1'($urandom_range(0, 1));
                    req.stamp  = random_stamp();
                    queue_request(req);
                end
            end
        endcase
    endtask

    // Waits until every request is taken and every byte has come, then lets the block settle.
    task automatic wait_drained();
        while (accepted_total != queued_total || expected_bytes.size() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_tap_window(input logic [15:0] value);
        @(negedge clk);
        cfg_valid  <= 1'b1;
        cfg_window <= value;
        do @(posedge clk); while (!cfg_ready);
        window_ms = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Key channel: accept at the rising edge, present the next request at the falling edge.
    always @(posedge clk) begin : key_accept
        if (rst_n && key_valid && key_if.ready) begin
            encode_key_request(key_req);
            accepted_total++;
            key_taken = 1'b1;
        end
    end

    always @(negedge clk) begin : key_driver
        if (!key_valid || key_taken) begin
            if (key_gap != 0) begin
                key_gap--;
                key_valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
                key_req   <= pending_reqs.pop_front();
                key_valid <= 1'b1;
                key_gap = pick_idle(key_calm);
            end else begin
                key_valid <= 1'b0;
            end
        end
        key_taken = 1'b0;
    end

    always @(negedge clk) begin : byte_stall
        if (stall_left != 0) begin
            stall_left--;
            byte_ready <= 1'b0;
        end else begin
            byte_ready <= 1'b1;
            stall_left = pick_idle(byte_calm);
        end
    end

    always @(posedge clk) begin : byte_monitor
        t_out_byte want;
        if (rst_n && byte_if.valid && byte_ready) begin
            if (expected_bytes.size() == 0) begin
                note_mismatch("byte with nothing expected", 0, 32'(byte_if.byte_value));
            end else begin
                want = expected_bytes.pop_front();
                if (want.value != byte_if.byte_value) begin
                    note_mismatch("byte_value", 32'(want.value), 32'(byte_if.byte_value));
                end
                if (want.last != byte_if.last_byte) begin
                    note_mismatch("last_byte", 32'(want.last), 32'(byte_if.last_byte));
                end
            end
        end
    end

    always @(posedge clk) begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        logic [15:0] windows [5];
        windows[0] = 16'd0;
        windows[1] = 16'hFFFF;
        windows[2] = 16'($urandom_range(2, 65534));
        windows[3] = 16'd1;
        windows[4] = TAP_WINDOW_RESET;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part with the window at its reset value.
        queue_key(CHAR_LOWER_A, CHAR_UPPER_A, 1'b1);
        queue_tap(48'd1000);
        queue_key(21'h7F, 21'h7FF, 1'b0);               // shift picks the two-byte code
        queue_tap(48'd2000);
        queue_tap(48'd2600);                            // gap equal to the window locks caps
        queue_key(CHAR_LOWER_A + 21'd16, CHAR_UPPER_A + 21'd16, 1'b1);
        queue_key(21'h800, 21'hFFFF, 1'b0);             // caps leaves non-letters alone
        queue_tap(48'd3000);                            // a tap releases caps
        queue_arm(MODE_ALT);
        queue_key(21'h10000, '0, 1'b0);                 // ESC and four bytes
        queue_arm(MODE_CTRL);
        queue_key(CHAR_LOWER_A + 21'd2, CHAR_UPPER_A + 21'd2, 1'b1);
        queue_arm(MODE_CTRL);
        queue_key(CHAR_SPACE, CHAR_SPACE, 1'b0);
        queue_arm(MODE_ALT);
        queue_arm(MODE_CTRL);
        queue_key(CHAR_QUESTION, CHAR_QUESTION, 1'b0);
        queue_arm(MODE_CTRL);
        queue_arm(MODE_ALT);
        queue_key(21'h31, 21'h21, 1'b0);                // no ctrl mapping: modifiers stay
        queue_key(21'h5B, 21'h7B, 1'b0);
        queue_tap('0);                                  // stamp of zero records no tap
        queue_tap(48'd5);
        queue_tap(48'd700);
        queue_tap(48'd3);                               // earlier stamp counts as within
        queue_key('0, CODE_MAX, 1'b1);
        queue_tap(48'hFFFF_FFFF_FFFF);

        foreach (windows[p]) begin
            wait_drained();
            write_tap_window(windows[p]);
            // Taps right at the window edge and one past it.
            queue_caps_cycle({32'd0, window_ms}, {32'd0, window_ms} + 48'd1);
            queue_caps_cycle({32'd0, window_ms} + 48'd1, {32'd0, window_ms});
            while (queued_total < (p + 1) * PHASE_ITEMS + 40) begin
                queue_scenario();
            end
        end

        wait_drained();
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
